/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define BDH_ASSERT_ALWAYS(name, clk, rst_n, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// ante implies cons in the same cycle
`define BDH_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante implies cons in the next cycle
`define BDH_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/bdh_pkg.sv */
// ----------------------------------------------------------------------------
// bdh_pkg
// Constants and register codes for the button debounce / hold detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdh_pkg;

	localparam int BUTTONS   = 4;
	localparam int BTN_IDX_W = 2;
	localparam int TIME_W    = 32;
	localparam int MS_W      = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE_MS = 3'd0,
		REG_HOLD_MS     = 3'd1,
		REG_HOLDOFF_MS  = 3'd2,
		REG_ACTIVE_HIGH = 3'd3,
		REG_ENABLE      = 3'd4
	} cfg_reg_t;

endpackage

/* rtl/button_debounce_hold_detector_core.sv */
// ----------------------------------------------------------------------------
// button_debounce_hold_detector_core
// Per-button debounce, hold-time press detection and press holdoff.
// ----------------------------------------------------------------------------
// Takes one poll sample per cycle, while the result side does not stall, and
// returns one result per sample, in order. A sample is captured in an input
// register; when the result register can take it, a single pass of
// compare/subtract logic reads the button's state flip-flops, updates them
// (enabled buttons only) and loads the result register. Configuration writes
// are always ready and should only be issued while no sample is in flight.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module button_debounce_hold_detector_core
	import bdh_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  logic [BTN_IDX_W-1:0]  button_index,
	input  logic                  raw_level,
	input  logic [TIME_W-1:0]     now_ms,

	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [BTN_IDX_W-1:0]  event_button,
	output logic                  press_event,
	output logic                  debounced_active,
	output logic                  event_level,
	output logic [TIME_W-1:0]     event_time_ms
);

	// configuration
	logic [MS_W-1:0]    debounce_ms_q;
	logic [MS_W-1:0]    hold_ms_q;
	logic [MS_W-1:0]    holdoff_ms_q;
	logic [BUTTONS-1:0] active_high_q;
	logic [BUTTONS-1:0] enable_q;

	// per-button state
	logic [BUTTONS-1:0] raw_q;
	logic [BUTTONS-1:0] active_q;
	logic [BUTTONS-1:0] wait_rel_q;
	logic [BUTTONS-1:0] hold_valid_q;
	logic [TIME_W-1:0]  change_time_q [BUTTONS];
	logic [TIME_W-1:0]  active_start_q [BUTTONS];
	logic [TIME_W-1:0]  deadline_q [BUTTONS];

	// input stage
	logic                 valid_s1;
	logic [BTN_IDX_W-1:0] button_s1;
	logic                 level_s1;
	logic [TIME_W-1:0]    now_s1;

	// result stage
	logic                 result_valid_q;
	logic [BTN_IDX_W-1:0] event_button_q;
	logic                 press_q;
	logic                 active_out_q;
	logic                 level_out_q;
	logic [TIME_W-1:0]    event_time_q;

	logic advance;
	logic load;

	// single-pass evaluation
	logic              en_c;
	logic              ah_c;
	logic              hv_c;
	logic              raw_c;
	logic              act_c;
	logic              wr_c;
	logic              press_c;
	logic [TIME_W-1:0] ct_c;
	logic [TIME_W-1:0] ast_c;
	logic [TIME_W-1:0] dl_c;
	logic [TIME_W-1:0] dl_diff;
	logic              new_active;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ms_q <= MS_W'(20);
			hold_ms_q     <= MS_W'(50);
			holdoff_ms_q  <= MS_W'(500);
			active_high_q <= '0;
			enable_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_DEBOUNCE_MS: debounce_ms_q <= cfg_data;
				REG_HOLD_MS:     hold_ms_q     <= cfg_data;
				REG_HOLDOFF_MS:  holdoff_ms_q  <= cfg_data;
				REG_ACTIVE_HIGH: active_high_q <= cfg_data[BUTTONS-1:0];
				REG_ENABLE:      enable_q      <= cfg_data[BUTTONS-1:0];
				default: ;
			endcase
		end
	end

	assign advance      = valid_s1 && (!result_valid_q || !result_stall);
	assign sample_stall = valid_s1 && !advance;
	assign load         = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			button_s1 <= button_index;
			level_s1  <= raw_level;
			now_s1    <= now_ms;
		end
	end

	always_comb begin
		en_c    = enable_q[button_s1];
		ah_c    = active_high_q[button_s1];
		hv_c    = hold_valid_q[button_s1];
		raw_c   = raw_q[button_s1];
		act_c   = active_q[button_s1];
		wr_c    = wait_rel_q[button_s1];
		ct_c    = change_time_q[button_s1];
		ast_c   = active_start_q[button_s1];
		dl_c    = deadline_q[button_s1];
		press_c = 1'b0;
		dl_diff = dl_c - now_s1;
		new_active = 1'b0;

		if (en_c) begin
			if (hv_c && ((dl_diff == '0) || dl_diff[TIME_W-1])) begin
				hv_c = 1'b0;
			end
			if (level_s1 != raw_c) begin
				raw_c = level_s1;
				ct_c  = now_s1;
				ast_c = (ah_c == level_s1) ? now_s1 : '0;
			end
			if ((now_s1 - ct_c) >= TIME_W'(debounce_ms_q)) begin
				new_active = (ah_c == raw_c);
				if (new_active != act_c) begin
					act_c = new_active;
					if (!new_active) begin
						wr_c = 1'b0;
					end
				end
				if (new_active && !wr_c && ((now_s1 - ast_c) >= TIME_W'(hold_ms_q))) begin
					wr_c = 1'b1;
					if (!hv_c) begin
						dl_c    = now_s1 + TIME_W'(holdoff_ms_q);
						hv_c    = 1'b1;
						press_c = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q        <= '1;
			active_q     <= '0;
			wait_rel_q   <= '0;
			hold_valid_q <= '0;
			for (int i = 0; i < BUTTONS; i++) begin
				change_time_q[i]  <= '0;
				active_start_q[i] <= '0;
				deadline_q[i]     <= '0;
			end
		end else if (advance && en_c) begin
			raw_q[button_s1]          <= raw_c;
			active_q[button_s1]       <= act_c;
			wait_rel_q[button_s1]     <= wr_c;
			hold_valid_q[button_s1]   <= hv_c;
			change_time_q[button_s1]  <= ct_c;
			active_start_q[button_s1] <= ast_c;
			deadline_q[button_s1]     <= dl_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_button_q <= button_s1;
			press_q        <= press_c;
			active_out_q   <= act_c;
			level_out_q    <= raw_c;
			event_time_q   <= now_s1;
		end
	end

	assign result_valid     = result_valid_q;
	assign event_button     = event_button_q;
	assign press_event      = press_q;
	assign debounced_active = active_out_q;
	assign event_level      = level_out_q;
	assign event_time_ms    = event_time_q;

	`BDH_ASSERT_ALWAYS(a_press_needs_enable, clk, arst_n, !press_c || en_c, "press on disabled button")
	`BDH_ASSERT_ALWAYS(a_press_is_active, clk, arst_n, !(result_valid_q && press_q) || active_out_q, "press while not active")
	`BDH_ASSERT_NEXT(a_press_arms_holdoff, clk, arst_n, advance && press_c, hold_valid_q[$past(button_s1)] && wait_rel_q[$past(button_s1)], "press did not arm holdoff")

endmodule
